/* rtl/core/stt_pkg.sv */
// Shared types, constants and helper functions for the source text tokenizer.
// No dependencies.
package stt_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_W      = 20;
  localparam int COL_W       = 16;
  localparam int SPAN_W      = 16;
  localparam int KBUF_W      = 40;
  localparam int DATA_BITS   = 3 + LINE_W + COL_W + OFFSET_BITS + SPAN_W + 8;
  localparam int OUT_DATA_W  = ((DATA_BITS + 7) / 8) * 8;
  localparam int KIND_W      = 5;

  localparam logic [LINE_W-1:0]      LINE_MAX = '1;
  localparam logic [COL_W-1:0]       COL_MAX  = '1;
  localparam logic [SPAN_W-1:0]      SPAN_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;

  typedef enum logic [KIND_W-1:0] {
    K_END     = 5'd0,
    K_IDENT   = 5'd1,
    K_LET     = 5'd2,
    K_PRINT   = 5'd3,
    K_INT     = 5'd4,
    K_CHARKW  = 5'd5,
    K_STR     = 5'd6,
    K_NUMBER  = 5'd7,
    K_SLASH   = 5'd8,
    K_CHARLIT = 5'd9,
    K_STRING  = 5'd10,
    K_COLON   = 5'd11,
    K_SEMI    = 5'd12,
    K_ASSIGN  = 5'd13,
    K_LPAREN  = 5'd14,
    K_RPAREN  = 5'd15,
    K_UNKNOWN = 5'd16,
    K_ERROR   = 5'd17
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE       = 3'd0,
    E_CHAR_ESC   = 3'd1,
    E_CHAR_BAD   = 3'd2,
    E_STR_ESC    = 3'd3,
    E_STR_UNTERM = 3'd4
  } err_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // keyword text, first byte in the low bits
  localparam logic [23:0] KW_LET   = 24'h74656C;
  localparam logic [39:0] KW_PRINT = 40'h746E697270;
  localparam logic [23:0] KW_INT   = 24'h746E69;
  localparam logic [31:0] KW_CHAR  = 32'h72616863;
  localparam logic [23:0] KW_STR   = 24'h727473;

  typedef struct packed {
    logic [LINE_W-1:0]      line;
    logic [COL_W-1:0]       col;
    logic [OFFSET_BITS-1:0] off;
    logic [SPAN_W-1:0]      span;
  } pos_t;

  typedef struct packed {
    kind_t                  kind;
    err_t                   err;
    logic [LINE_W-1:0]      line;
    logic [COL_W-1:0]       col;
    logic [OFFSET_BITS-1:0] off;
    logic [SPAN_W-1:0]      span;
    logic [7:0]             cval;
    logic                   last;
  } item_t;

  function automatic logic is_space(logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_break(logic [7:0] b);
    return b inside {CH_NUL, CH_LF, CH_CR};
  endfunction

  function automatic pos_t adv_pos(pos_t p, logic [7:0] b);
    pos_t q;
    q = p;
    if (p.off != OFF_MAX) q.off = p.off + 1'b1;
    if (b == CH_LF) begin
      if (p.line != LINE_MAX) q.line = p.line + 1'b1;
      q.col = COL_W'(1);
    end else if (p.col != COL_MAX) begin
      q.col = p.col + 1'b1;
    end
    if (p.span != SPAN_MAX) q.span = p.span + 1'b1;
    return q;
  endfunction

  function automatic kind_t ident_kind(logic [KBUF_W-1:0] kb, logic [SPAN_W-1:0] span);
    kind_t k;
    k = K_IDENT;
    if (span == SPAN_W'(3) && kb[23:0] == KW_LET) k = K_LET;
    else if (span == SPAN_W'(5) && kb[39:0] == KW_PRINT) k = K_PRINT;
    else if (span == SPAN_W'(3) && kb[23:0] == KW_INT) k = K_INT;
    else if (span == SPAN_W'(4) && kb[31:0] == KW_CHAR) k = K_CHARKW;
    else if (span == SPAN_W'(3) && kb[23:0] == KW_STR) k = K_STR;
    return k;
  endfunction

endpackage

/* rtl/core/source_text_tokenizer.sv */
// Source text tokenizer: one byte in, up to two tokens out through a small queue.
// Tokens go into a registered result queue and are presented on out_* from its head.
// Throughput: one byte per cycle while the queue holds two tokens or fewer; a byte that
//   yields two tokens pushes both into a four-entry result queue behind the single output port.
// Reset (rst_n low, synchronous): scanner idle, line 1, column 1, offset 0, queue empty.
// Depends on stt_pkg.
module source_text_tokenizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // ch
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // error_code, tok_line, tok_col, start_offset, span_length, char_value
  output logic [stt_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [stt_pkg::KIND_W-1:0]        out_tuser,  // kind
  output logic                              out_tlast   // last
);

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_IDENT   = 9'b000000010,
    M_NUM     = 9'b000000100,
    M_SLASH   = 9'b000001000,
    M_COMMENT = 9'b000010000,
    M_CBODY   = 9'b000100000,
    M_CESC    = 9'b001000000,
    M_SBODY   = 9'b010000000,
    M_SESC    = 9'b100000000
  } mode_t;

  mode_t                              mode_r, mode_nxt;
  stt_pkg::pos_t                      cur_r, cur_nxt;
  logic [stt_pkg::LINE_W-1:0]         sline_r, sline_nxt;
  logic [stt_pkg::COL_W-1:0]          scol_r, scol_nxt;
  logic [stt_pkg::OFFSET_BITS-1:0]    spos_r, spos_nxt;
  logic [stt_pkg::KBUF_W-1:0]         kbuf_r, kbuf_nxt;
  logic [1:0]                         lcnt_r, lcnt_nxt;
  logic [7:0]                         fbyte_r, fbyte_nxt;

  stt_pkg::item_t                     q_r [4];
  logic [1:0]                         wr_ptr_r, rd_ptr_r;
  logic [2:0]                         cnt_r;

  logic                               acc, pop, rescan;
  logic                               emit_a, emit_b;
  stt_pkg::item_t                     item_a, item_b, item0, item1;
  logic [7:0]                         b;
  logic [1:0]                         n_push;

  assign b         = in_tdata;
  assign in_tready = (cnt_r <= 3'd2);
  assign acc       = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  function automatic stt_pkg::item_t mk_item(
    stt_pkg::kind_t k, stt_pkg::err_t e, logic [7:0] cv,
    logic [stt_pkg::LINE_W-1:0] l, logic [stt_pkg::COL_W-1:0] c,
    logic [stt_pkg::OFFSET_BITS-1:0] o, logic [stt_pkg::SPAN_W-1:0] s);
    stt_pkg::item_t it;
    it.kind = k;
    it.err  = e;
    it.line = l;
    it.col  = c;
    it.off  = o;
    it.span = s;
    it.cval = cv;
    it.last = 1'b1;
    return it;
  endfunction

  always_comb begin
    mode_nxt  = mode_r;
    cur_nxt   = cur_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    spos_nxt  = spos_r;
    kbuf_nxt  = kbuf_r;
    lcnt_nxt  = lcnt_r;
    fbyte_nxt = fbyte_r;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    item_a    = '0;
    item_b    = '0;
    rescan    = 1'b0;
    if (acc) begin
      case (mode_r)
        M_IDENT: begin
          if (stt_pkg::is_alpha(b) || stt_pkg::is_digit(b)) begin
            if (cur_r.span < stt_pkg::SPAN_W'(5))
              kbuf_nxt[{cur_r.span[2:0], 3'b000} +: 8] = b;
            cur_nxt = stt_pkg::adv_pos(cur_r, b);
          end else begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::ident_kind(kbuf_r, cur_r.span), stt_pkg::E_NONE,
                             8'h00, sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end
        end
        M_NUM: begin
          if (stt_pkg::is_digit(b) || b == stt_pkg::CH_DOT) begin
            cur_nxt = stt_pkg::adv_pos(cur_r, b);
          end else begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::K_NUMBER, stt_pkg::E_NONE, 8'h00,
                             sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == stt_pkg::CH_SLASH) begin
            cur_nxt  = stt_pkg::adv_pos(cur_r, b);
            mode_nxt = M_COMMENT;
          end else begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::K_SLASH, stt_pkg::E_NONE, 8'h00,
                             sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end
        end
        M_COMMENT: begin
          if (b == stt_pkg::CH_NUL) begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::K_SLASH, stt_pkg::E_NONE, 8'h00,
                             sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end else if (stt_pkg::is_break(b)) begin
            rescan = 1'b1;
          end else begin
            cur_nxt = stt_pkg::adv_pos(cur_r, b);
          end
        end
        M_CBODY: begin
          if (stt_pkg::is_break(b)) begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::K_ERROR, stt_pkg::E_CHAR_BAD, 8'h00,
                             sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end else if (b == stt_pkg::CH_QUOTE) begin
            cur_nxt  = stt_pkg::adv_pos(cur_r, b);
            mode_nxt = M_IDLE;
            emit_a   = 1'b1;
            if (lcnt_r == 2'd1)
              item_a = mk_item(stt_pkg::K_CHARLIT, stt_pkg::E_NONE, fbyte_r,
                               sline_r, scol_r, spos_r, cur_nxt.span);
            else
              item_a = mk_item(stt_pkg::K_ERROR, stt_pkg::E_CHAR_BAD, 8'h00,
                               sline_r, scol_r, spos_r, cur_nxt.span);
          end else begin
            if (cur_r.span == stt_pkg::SPAN_W'(1)) fbyte_nxt = b;
            cur_nxt = stt_pkg::adv_pos(cur_r, b);
            if (b == stt_pkg::CH_BSLASH) mode_nxt = M_CESC;
            else if (lcnt_r != 2'd2) lcnt_nxt = lcnt_r + 2'd1;
          end
        end
        M_CESC: begin
          if (stt_pkg::is_break(b)) begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::K_ERROR, stt_pkg::E_CHAR_ESC, 8'h00,
                             sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end else begin
            cur_nxt = stt_pkg::adv_pos(cur_r, b);
            if (lcnt_r != 2'd2) lcnt_nxt = lcnt_r + 2'd1;
            mode_nxt = M_CBODY;
          end
        end
        M_SBODY: begin
          if (stt_pkg::is_break(b)) begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::K_ERROR, stt_pkg::E_STR_UNTERM, 8'h00,
                             sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end else if (b == stt_pkg::CH_DQUOTE) begin
            cur_nxt  = stt_pkg::adv_pos(cur_r, b);
            mode_nxt = M_IDLE;
            emit_a   = 1'b1;
            item_a   = mk_item(stt_pkg::K_STRING, stt_pkg::E_NONE, 8'h00,
                               sline_r, scol_r, spos_r, cur_nxt.span);
          end else begin
            cur_nxt = stt_pkg::adv_pos(cur_r, b);
            if (b == stt_pkg::CH_BSLASH) mode_nxt = M_SESC;
          end
        end
        M_SESC: begin
          if (stt_pkg::is_break(b)) begin
            emit_a = 1'b1;
            item_a = mk_item(stt_pkg::K_ERROR, stt_pkg::E_STR_ESC, 8'h00,
                             sline_r, scol_r, spos_r, cur_r.span);
            rescan = 1'b1;
          end else begin
            cur_nxt  = stt_pkg::adv_pos(cur_r, b);
            mode_nxt = M_SBODY;
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase

      // fresh scan of the byte (idle, or a token just closed by it)
      if (rescan) begin
        mode_nxt = M_IDLE;
        if (stt_pkg::is_space(b)) begin
          cur_nxt = stt_pkg::adv_pos(cur_r, b);
        end else begin
          sline_nxt    = cur_r.line;
          scol_nxt     = cur_r.col;
          spos_nxt     = cur_r.off;
          cur_nxt.span = '0;
          kbuf_nxt     = '0;
          lcnt_nxt     = '0;
          fbyte_nxt    = '0;
          if (b == stt_pkg::CH_NUL) begin
            emit_b    = 1'b1;
            item_b    = mk_item(stt_pkg::K_END, stt_pkg::E_NONE, 8'h00,
                                cur_r.line, cur_r.col, cur_r.off, '0);
            cur_nxt.line = stt_pkg::LINE_W'(1);
            cur_nxt.col  = stt_pkg::COL_W'(1);
            cur_nxt.off  = '0;
            sline_nxt    = stt_pkg::LINE_W'(1);
            scol_nxt     = stt_pkg::COL_W'(1);
            spos_nxt     = '0;
          end else if (stt_pkg::is_alpha(b)) begin
            kbuf_nxt = stt_pkg::KBUF_W'(b);
            cur_nxt  = stt_pkg::adv_pos(cur_nxt, b);
            mode_nxt = M_IDENT;
          end else if (stt_pkg::is_digit(b) || b == stt_pkg::CH_DOT) begin
            cur_nxt  = stt_pkg::adv_pos(cur_nxt, b);
            mode_nxt = M_NUM;
          end else begin
            cur_nxt = stt_pkg::adv_pos(cur_nxt, b);
            case (b)
              stt_pkg::CH_SLASH:  mode_nxt = M_SLASH;
              stt_pkg::CH_QUOTE:  mode_nxt = M_CBODY;
              stt_pkg::CH_DQUOTE: mode_nxt = M_SBODY;
              default: begin
                emit_b = 1'b1;
                item_b = mk_item(stt_pkg::K_UNKNOWN, stt_pkg::E_NONE, 8'h00,
                                 cur_r.line, cur_r.col, cur_r.off, cur_nxt.span);
                case (b)
                  stt_pkg::CH_COLON:  item_b.kind = stt_pkg::K_COLON;
                  stt_pkg::CH_SEMI:   item_b.kind = stt_pkg::K_SEMI;
                  stt_pkg::CH_EQ:     item_b.kind = stt_pkg::K_ASSIGN;
                  stt_pkg::CH_LPAREN: item_b.kind = stt_pkg::K_LPAREN;
                  stt_pkg::CH_RPAREN: item_b.kind = stt_pkg::K_RPAREN;
                  default:            item_b.kind = stt_pkg::K_UNKNOWN;
                endcase
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    item0      = emit_a ? item_a : item_b;
    item0.last = !(emit_a && emit_b);
    item1      = item_b;
    n_push     = {1'b0, emit_a} + {1'b0, emit_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      cur_r    <= '{line: stt_pkg::LINE_W'(1), col: stt_pkg::COL_W'(1), off: '0, span: '0};
      sline_r  <= stt_pkg::LINE_W'(1);
      scol_r   <= stt_pkg::COL_W'(1);
      spos_r   <= '0;
      kbuf_r   <= '0;
      lcnt_r   <= '0;
      fbyte_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      cur_r    <= cur_nxt;
      sline_r  <= sline_nxt;
      scol_r   <= scol_nxt;
      spos_r   <= spos_nxt;
      kbuf_r   <= kbuf_nxt;
      lcnt_r   <= lcnt_nxt;
      fbyte_r  <= fbyte_nxt;
      wr_ptr_r <= wr_ptr_r + n_push;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r    <= cnt_r + {1'b0, n_push} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_r[wr_ptr_r] <= item0;
    if (n_push == 2'd2) q_r[wr_ptr_r + 2'd1] <= item1;
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tuser  = q_r[rd_ptr_r].kind;
  assign out_tlast  = q_r[rd_ptr_r].last;
  assign out_tdata  = stt_pkg::OUT_DATA_W'({q_r[rd_ptr_r].cval, q_r[rd_ptr_r].span,
                                            q_r[rd_ptr_r].off, q_r[rd_ptr_r].col,
                                            q_r[rd_ptr_r].line, q_r[rd_ptr_r].err});

endmodule

/* sim/token_checker.sv */
`timescale 1ns / 100ps
// Token checker for the source text tokenizer: watches the byte and token streams,
// rebuilds the expected tokens from each accepted byte and compares them in order.
// Depends on stt_pkg.
module token_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [stt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [stt_pkg::KIND_W-1:0]     out_tuser,
  input  logic                           out_tlast,
  output int                             n_errors,
  output int                             n_pending
);
  import stt_pkg::*;

  localparam int LINE_LO = 3;
  localparam int COL_LO  = LINE_LO + LINE_W;
  localparam int OFF_LO  = COL_LO + COL_W;
  localparam int SPAN_LO = OFF_LO + OFFSET_BITS;
  localparam int CVAL_LO = SPAN_LO + SPAN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_WORD, S_NUM, S_SLASH, S_NOTE, S_CHR, S_CHR_ESC, S_STR, S_STR_ESC
  } scan_t;

  scan_t                  mode = S_IDLE;
  logic [LINE_W-1:0]      at_line, tk_line;
  logic [COL_W-1:0]       at_col, tk_col;
  logic [OFFSET_BITS-1:0] at_off, tk_off;
  logic [SPAN_W-1:0]      tk_span;
  logic [39:0]            word;   // first five bytes, first byte highest
  logic [1:0]             lit_n;
  logic [7:0]             lit_first;
  item_t                  due_tokens[$];
  int                     step_n;
  int                     seen = 0;
  int                     fails = 0;
  int                     waiting = 0;

  assign n_errors  = fails;
  assign n_pending = waiting;

  function automatic logic blank_ch(logic [7:0] b);
    return b == " " || (b >= 8'h09 && b <= CH_CR);
  endfunction

  function automatic logic letter_ch(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic numeral_ch(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic stop_ch(logic [7:0] b);
    return b == CH_NUL || b == CH_LF || b == CH_CR;
  endfunction

  function automatic kind_t word_kind(logic [39:0] w, logic [SPAN_W-1:0] n);
    kind_t k;
    k = K_IDENT;
    if (n == 3 && w[23:0] == "let") k = K_LET;
    else if (n == 3 && w[23:0] == "int") k = K_INT;
    else if (n == 3 && w[23:0] == "str") k = K_STR;
    else if (n == 4 && w[31:0] == "char") k = K_CHARKW;
    else if (n == 5 && w == "print") k = K_PRINT;
    return k;
  endfunction

  task automatic restart();
    mode = S_IDLE;
    at_line = LINE_W'(1);
    at_col = COL_W'(1);
    at_off = '0;
    tk_line = LINE_W'(1);
    tk_col = COL_W'(1);
    tk_off = '0;
    tk_span = '0;
    word = '0;
    lit_n = '0;
    lit_first = '0;
  endtask

  task automatic step_pos(input logic [7:0] b);
    if (~&at_off) at_off = at_off + 1'b1;
    if (b == CH_LF) begin
      if (~&at_line) at_line = at_line + 1'b1;
      at_col = COL_W'(1);
    end else if (~&at_col) begin
      at_col = at_col + 1'b1;
    end
    if (~&tk_span) tk_span = tk_span + 1'b1;
  endtask

  task automatic open_token();
    tk_line = at_line;
    tk_col = at_col;
    tk_off = at_off;
    tk_span = '0;
    word = '0;
    lit_n = '0;
    lit_first = '0;
  endtask

  task automatic queue_token(input kind_t k, input err_t e, input logic [7:0] v);
    item_t t;
    t.kind = k;
    t.err = e;
    t.line = tk_line;
    t.col = tk_col;
    t.off = tk_off;
    t.span = tk_span;
    t.cval = v;
    t.last = 1'b0;
    due_tokens.push_back(t);
    step_n++;
  endtask

  task automatic scan_fresh(input logic [7:0] b);
    mode = S_IDLE;
    if (blank_ch(b)) begin
      step_pos(b);
    end else begin
      open_token();
      if (b == CH_NUL) begin
        queue_token(K_END, E_NONE, 8'h00);
        restart();
      end else begin
        if (letter_ch(b)) word = {32'h0, b};
        step_pos(b);
        if (letter_ch(b)) mode = S_WORD;
        else if (numeral_ch(b) || b == CH_DOT) mode = S_NUM;
        else begin
          case (b)
            CH_SLASH:  mode = S_SLASH;
            CH_QUOTE:  mode = S_CHR;
            CH_DQUOTE: mode = S_STR;
            CH_COLON:  queue_token(K_COLON, E_NONE, 8'h00);
            CH_SEMI:   queue_token(K_SEMI, E_NONE, 8'h00);
            CH_EQ:     queue_token(K_ASSIGN, E_NONE, 8'h00);
            CH_LPAREN: queue_token(K_LPAREN, E_NONE, 8'h00);
            CH_RPAREN: queue_token(K_RPAREN, E_NONE, 8'h00);
            default:   queue_token(K_UNKNOWN, E_NONE, 8'h00);
          endcase
        end
      end
    end
  endtask

  task automatic lex_byte(input logic [7:0] b);
    item_t t;
    step_n = 0;
    case (mode)
      S_WORD: begin
        if (letter_ch(b) || numeral_ch(b)) begin
          if (tk_span < 5) word = {word[31:0], b};
          step_pos(b);
        end else begin
          queue_token(word_kind(word, tk_span), E_NONE, 8'h00);
          scan_fresh(b);
        end
      end
      S_NUM: begin
        if (numeral_ch(b) || b == CH_DOT) step_pos(b);
        else begin
          queue_token(K_NUMBER, E_NONE, 8'h00);
          scan_fresh(b);
        end
      end
      S_SLASH: begin
        if (b == CH_SLASH) begin
          step_pos(b);
          mode = S_NOTE;
        end else begin
          queue_token(K_SLASH, E_NONE, 8'h00);
          scan_fresh(b);
        end
      end
      S_NOTE: begin
        if (b == CH_NUL) begin
          queue_token(K_SLASH, E_NONE, 8'h00);
          scan_fresh(b);
        end else if (stop_ch(b)) begin
          scan_fresh(b);
        end else begin
          step_pos(b);
        end
      end
      S_CHR: begin
        if (stop_ch(b)) begin
          queue_token(K_ERROR, E_CHAR_BAD, 8'h00);
          scan_fresh(b);
        end else if (b == CH_QUOTE) begin
          step_pos(b);
          mode = S_IDLE;
          if (lit_n == 1) queue_token(K_CHARLIT, E_NONE, lit_first);
          else queue_token(K_ERROR, E_CHAR_BAD, 8'h00);
        end else begin
          if (tk_span == 1) lit_first = b;
          step_pos(b);
          if (b == CH_BSLASH) mode = S_CHR_ESC;
          else if (lit_n != 2) lit_n = lit_n + 1'b1;
        end
      end
      S_CHR_ESC: begin
        if (stop_ch(b)) begin
          queue_token(K_ERROR, E_CHAR_ESC, 8'h00);
          scan_fresh(b);
        end else begin
          step_pos(b);
          if (lit_n != 2) lit_n = lit_n + 1'b1;
          mode = S_CHR;
        end
      end
      S_STR: begin
        if (stop_ch(b)) begin
          queue_token(K_ERROR, E_STR_UNTERM, 8'h00);
          scan_fresh(b);
        end else if (b == CH_DQUOTE) begin
          step_pos(b);
          mode = S_IDLE;
          queue_token(K_STRING, E_NONE, 8'h00);
        end else begin
          step_pos(b);
          if (b == CH_BSLASH) mode = S_STR_ESC;
        end
      end
      S_STR_ESC: begin
        if (stop_ch(b)) begin
          queue_token(K_ERROR, E_STR_ESC, 8'h00);
          scan_fresh(b);
        end else begin
          step_pos(b);
          mode = S_STR;
        end
      end
      default: scan_fresh(b);
    endcase
    if (step_n > 0) begin
      t = due_tokens.pop_back();
      t.last = 1'b1;
      due_tokens.push_back(t);
    end
  endtask

  task automatic report(input string what, input longint got_v, input longint want_v);
    if (fails < 100)
      $display("%0t token %0d: %s is %0d, expected %0d", $time, seen, what, got_v, want_v);
    fails++;
  endtask

  always @(posedge clk) begin
    item_t got, want;
    if (!rst_n) begin
      restart();
      due_tokens.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind = kind_t'(out_tuser);
        got.err  = err_t'(out_tdata[2:0]);
        got.line = out_tdata[LINE_LO +: LINE_W];
        got.col  = out_tdata[COL_LO +: COL_W];
        got.off  = out_tdata[OFF_LO +: OFFSET_BITS];
        got.span = out_tdata[SPAN_LO +: SPAN_W];
        got.cval = out_tdata[CVAL_LO +: 8];
        got.last = out_tlast;
        if (due_tokens.size() == 0) begin
          report("unexpected token, kind", got.kind, -1);
        end else begin
          want = due_tokens.pop_front();
          if (got.kind !== want.kind) report("kind", got.kind, want.kind);
          if (got.err !== want.err) report("error_code", got.err, want.err);
          if (got.line !== want.line) report("tok_line", got.line, want.line);
          if (got.col !== want.col) report("tok_col", got.col, want.col);
          if (got.off !== want.off) report("start_offset", got.off, want.off);
          if (got.span !== want.span) report("span_length", got.span, want.span);
          if (got.cval !== want.cval) report("char_value", got.cval, want.cval);
          if (got.last !== want.last) report("last", got.last, want.last);
        end
        seen++;
      end
      if (in_tvalid && in_tready) lex_byte(in_tdata);
    end
    waiting = due_tokens.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top: drives source bytes and back-pressure into source_text_tokenizer
// through several idling phases, prints the verdict; also needs stt_pkg, token_checker.
module tb_top;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int BYTES_PER_MODE = 130;
  localparam int DRAIN_CYCLES   = 16;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [7:0]            in_tdata = 8'h00;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  int                    n_errors;
  int                    n_pending;
  int                    src_idle = 0;
  int                    sink_stall = 0;
  int                    sent = 0;
  int                    cycles = 0;
  string                 kw_list[5] = '{"let", "print", "int", "char", "str"};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  source_text_tokenizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  token_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .n_errors   (n_errors),
    .n_pending  (n_pending)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // any byte that neither breaks a line nor opens, closes or escapes a literal
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_LF || b == CH_CR || b == CH_QUOTE || b == CH_DQUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] cut_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return CH_NUL;
    if (r < 11) return CH_LF;
    return CH_CR;
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  task automatic send_random_token();
    int pick, n;
    string marks, gaps;
    marks = "/:;=()";
    gaps = " \t\n\v\f";
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_text(kw_list[$urandom_range(0, 4)]);
    end else if (pick < 27) begin
      push_byte(pick_letter());
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) push_byte(8'("0" + $urandom_range(0, 9)));
        else push_byte(pick_letter());
      end
    end else if (pick < 37) begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 4) == 0) push_byte(CH_DOT);
        else push_byte(8'("0" + $urandom_range(0, 9)));
      end
    end else if (pick < 52) begin
      push_byte(marks[$urandom_range(0, 5)]);
    end else if (pick < 64) begin
      push_byte(CH_QUOTE);
      n = $urandom_range(0, 9);
      if (n < 6) begin
        push_byte(body_byte());
      end else if (n == 6) begin
        push_byte(CH_BSLASH);
        if ($urandom_range(0, 3) == 0) begin
          push_byte(cut_byte());
          return;
        end
        push_byte(body_byte());
      end else if (n == 8) begin
        repeat ($urandom_range(2, 3)) push_byte(body_byte());
      end
      if ($urandom_range(0, 9) != 0) push_byte(CH_QUOTE);
      else push_byte(cut_byte());
    end else if (pick < 74) begin
      push_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 4) != 0) begin
          push_byte(body_byte());
        end else begin
          push_byte(CH_BSLASH);
          n = $urandom_range(0, 2);
          if (n == 0) push_byte(CH_DQUOTE);
          else if (n == 1) push_byte(CH_BSLASH);
          else push_byte(body_byte());
        end
      end
      n = $urandom_range(0, 19);
      if (n < 17) begin
        push_byte(CH_DQUOTE);
      end else begin
        if (n == 17) push_byte(CH_BSLASH);
        push_byte(cut_byte());
      end
    end else if (pick < 81) begin
      push_byte(CH_SLASH);
      push_byte(CH_SLASH);
      repeat ($urandom_range(0, 8)) push_byte(body_byte());
      push_byte(cut_byte());
    end else if (pick < 88) begin
      if ($urandom_range(0, 5) == 0) push_byte(CH_CR);
      else push_byte(gaps[$urandom_range(0, 4)]);
    end else if (pick < 98) begin
      push_byte(8'($urandom_range(1, 255)));
    end else begin
      push_byte(CH_NUL);
    end
    if ($urandom_range(0, 1)) push_byte($urandom_range(0, 3) ? " " : CH_LF);
  endtask

  initial begin
    int target;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    send_text("let print\tint\vchar\fstr Str x9 7.25/x//c\n:;=()");
    send_text("'a''\\n''ab''''");
    push_byte(CH_QUOTE);
    push_byte(CH_CR);
    push_byte(CH_QUOTE);
    push_byte(CH_BSLASH);
    push_byte(CH_LF);
    send_text("\"hi\\\"x\"\"ab");
    push_byte(CH_LF);
    push_byte(CH_DQUOTE);
    push_byte(CH_BSLASH);
    push_byte(CH_CR);
    push_byte(8'h80);
    push_byte(8'hFF);
    push_byte(8'h01);
    send_text("abc");
    push_byte(CH_NUL);
    send_text("\"open");
    push_byte(CH_NUL);
    send_text("//tail");
    push_byte(CH_NUL);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle = 0;
          sink_stall = 0;
        end
        1: begin
          src_idle = 64;
          sink_stall = 0;
        end
        2: begin
          src_idle = 0;
          sink_stall = 64;
        end
        default: begin
          src_idle = 34;
          sink_stall = 34;
        end
      endcase
      target = sent + BYTES_PER_MODE;
      while (sent < target) send_random_token();
      drain();
    end

    push_byte(CH_NUL);
    drain();
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* source_text_tokenizer.f */
rtl/core/stt_pkg.sv
rtl/core/source_text_tokenizer.sv
sim/token_checker.sv
sim/tb_top.sv
